// ===== src/irc_tok_pkg.sv =====
// Shared types and constants for the IRC line tokenizer.
// Used by irc_tok_core, irc_tok_fifo and irc_line_tokenizer_unit.
`default_nettype none
package irc_tok_pkg;

  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteColon = 8'h3A;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] CountMax  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOT  = 2'd1,
    KIND_EOL  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_PLAIN = 3'b010,
    MODE_TRAIL = 3'b100
  } mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_byte;
    logic [7:0] token_index;
    logic       first_in_token;
    logic       in_trailing;
    logic       last;
  } result_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == ByteSpace) || ((b >= ByteTab) && (b <= ByteCr));
  endfunction

  function automatic result_t mk_res(kind_e k, logic [7:0] ch, logic [7:0] idx,
                                     logic first, logic trail);
    result_t r;
    r.kind           = k;
    r.char_byte      = ch;
    r.token_index    = idx;
    r.first_in_token = first;
    r.in_trailing    = trail;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/irc_tok_core.sv =====
// Tokenizer state and per-byte decode: one word in, up to two results out.
// Depends on irc_tok_pkg.
`default_nettype none
module irc_tok_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           in_byte_i,
  output irc_tok_pkg::result_t      res0_o,
  output irc_tok_pkg::result_t      res1_o,
  output logic [1:0]                num_o
);
  import irc_tok_pkg::*;

  mode_e      mode_q, mode_d;
  logic       crp_q, crp_d;
  logic [7:0] cnt_q, cnt_d;
  logic       thc_q, thc_d;
  logic [7:0] cnt_inc;
  result_t    r0, r1;
  logic [1:0] num;

  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + 8'd1;

  always_comb begin
    mode_d = mode_q;
    crp_d  = crp_q;
    cnt_d  = cnt_q;
    thc_d  = thc_q;
    r0     = mk_res(KIND_EOL, 8'd0, 8'd0, 1'b0, 1'b0);
    r1     = mk_res(KIND_EOL, 8'd0, 8'd0, 1'b0, 1'b0);
    num    = 2'd0;
    if (in_byte_i == ByteLf) begin
      if (mode_q != MODE_IDLE) begin
        r0  = mk_res(KIND_EOT, 8'd0, cnt_q, 1'b0, mode_q == MODE_TRAIL);
        r1  = mk_res(KIND_EOL, 8'd0, cnt_inc, 1'b0, 1'b0);
        num = 2'd2;
      end else begin
        r0  = mk_res(KIND_EOL, 8'd0, cnt_q, 1'b0, 1'b0);
        num = 2'd1;
      end
      mode_d = MODE_IDLE;
      crp_d  = 1'b0;
      cnt_d  = 8'd0;
      thc_d  = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_TRAIL: begin
          // release a held CR ahead of this word
          if (crp_q) begin
            r0  = mk_res(KIND_CHAR, ByteCr, cnt_q, !thc_q, 1'b1);
            num = 2'd1;
            if (in_byte_i != ByteCr) begin
              r1  = mk_res(KIND_CHAR, in_byte_i, cnt_q, 1'b0, 1'b1);
              num = 2'd2;
            end
            thc_d = 1'b1;
          end else if (in_byte_i != ByteCr) begin
            r0    = mk_res(KIND_CHAR, in_byte_i, cnt_q, !thc_q, 1'b1);
            num   = 2'd1;
            thc_d = 1'b1;
          end
          crp_d = (in_byte_i == ByteCr);
        end
        MODE_PLAIN: begin
          if (is_ws(in_byte_i)) begin
            r0     = mk_res(KIND_EOT, 8'd0, cnt_q, 1'b0, 1'b0);
            cnt_d  = cnt_inc;
            mode_d = MODE_IDLE;
          end else begin
            r0 = mk_res(KIND_CHAR, in_byte_i, cnt_q, 1'b0, 1'b0);
          end
          num = 2'd1;
        end
        default: begin
          if (is_ws(in_byte_i)) begin
            mode_d = MODE_IDLE;
          end else if (in_byte_i == ByteColon) begin
            mode_d = MODE_TRAIL;
            crp_d  = 1'b0;
            thc_d  = 1'b0;
          end else begin
            r0     = mk_res(KIND_CHAR, in_byte_i, cnt_q, 1'b1, 1'b0);
            num    = 2'd1;
            mode_d = MODE_PLAIN;
          end
        end
      endcase
    end
    if (num == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      crp_q  <= 1'b0;
      cnt_q  <= 8'd0;
      thc_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      crp_q  <= crp_d;
      cnt_q  <= cnt_d;
      thc_q  <= thc_d;
    end
  end

  assign res0_o = r0;
  assign res1_o = r1;
  assign num_o  = num;

endmodule
`default_nettype wire

// ===== src/irc_tok_fifo.sv =====
// Result queue: takes zero, one or two results per cycle, hands out one.
// Depends on irc_tok_pkg.
`default_nettype none
module irc_tok_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [1:0]           push_num_i,
  input  irc_tok_pkg::result_t      push0_i,
  input  irc_tok_pkg::result_t      push1_i,
  output logic                      room2_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output irc_tok_pkg::result_t      head_o
);
  import irc_tok_pkg::*;

  localparam int Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] wr1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign room2_o     = (cnt_q <= 3'd2);
  assign head_o      = mem_q[rd_q];
  assign wr1         = wr_q + 2'd1;

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_q + push_num_i;
      if (pop) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_num_i} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ===== src/irc_line_tokenizer_unit.sv =====
// IRC line tokenizer top level: byte input channel, result output channel.
// Depends on irc_tok_pkg, irc_tok_core and irc_tok_fifo.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_byte_i) takes one raw stream
//   byte per word. Output channel (out_valid_o/out_ready_i) gives one
//   result per word: token characters, end-of-token marks and an end-of-line
//   mark carrying the token count; last_o flags the final result of a byte.
//   Each byte is decoded in the cycle it is accepted and its 0, 1 or 2
//   results are written to a four-entry result queue; the output is driven
//   from the registered head of that queue.
//   Throughput: one byte per cycle while the receiver keeps up. Bytes that
//   yield two results (LF ending a token, a held CR followed by a
//   character) occupy the output port once per result, so the output port
//   (one result per cycle) sets the sustained rate.
//   in_ready_o is high while the queue holds at most two results; when
//   the receiver stalls, input stops once three or four results wait,
//   and resumes as soon as the queue drains back to two.
//   Reset clears the queue and returns the tokenizer to the start of a line
//   between tokens.
`default_nettype none
module irc_line_tokenizer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      char_byte_o,
  output logic [7:0]      token_index_o,
  output logic            first_in_token_o,
  output logic            in_trailing_o,
  output logic            last_o
);
  import irc_tok_pkg::*;

  logic       accept;
  logic       room2;
  result_t    res0, res1, head;
  logic [1:0] num;
  logic [1:0] push_num;

  assign in_ready_o = room2;
  assign accept     = in_valid_i && room2;
  assign push_num   = accept ? num : 2'd0;

  irc_tok_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .res0_o    (res0),
    .res1_o    (res1),
    .num_o     (num)
  );

  irc_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o           = head.kind;
  assign char_byte_o      = head.char_byte;
  assign token_index_o    = head.token_index;
  assign first_in_token_o = head.first_in_token;
  assign in_trailing_o    = head.in_trailing;
  assign last_o           = head.last;

endmodule
`default_nettype wire
